/* sv/dss_pkg.sv */
package dss_pkg;

  // fixed widths of the Q16.16 datapath
  localparam int unsigned Q_W     = 32;
  localparam int unsigned MOP_W   = 33;          // multiplier operand
  localparam int unsigned MPR_W   = 2 * MOP_W;   // multiplier product
  localparam int unsigned DIV_W   = 64;          // divider dividend/divisor
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_POS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STIFF     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMP      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE    = 3'd7;

  // input command codes
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [Q_W-1:0] sat32(input logic signed [MPR_W-1:0] v);
    logic signed [MPR_W-1:0] hi;
    logic signed [MPR_W-1:0] lo;
    hi = MPR_W'(32'sh7fffffff);
    lo = -MPR_W'(33'sh080000000);
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[Q_W-1:0];
    end
  endfunction

endpackage

/* sv/dss_mul.sv */
module dss_mul (
  input  logic                               clk,
  input  logic signed [dss_pkg::MOP_W-1:0]   op_a,
  input  logic signed [dss_pkg::MOP_W-1:0]   op_b,
  output logic signed [dss_pkg::MPR_W-1:0]   prod_r
);
  import dss_pkg::*;

  // shared signed multiplier, product registered
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

/* sv/dss_div.sv */
module dss_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dss_pkg::DIV_W-1:0]   dividend,
  input  logic [dss_pkg::DIV_W-1:0]   divisor,
  output logic                        done_r,
  output logic [dss_pkg::DIV_W-1:0]   quo_r
);
  import dss_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_dif;

  // restoring division, one quotient bit a cycle
  assign rem_sh  = {rem_r, quo_r[DIV_W-1]};
  assign rem_dif = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        if (!rem_dif[DIV_W]) begin
          rem_r <= rem_dif[DIV_W-1:0];
          quo_r <= {quo_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[DIV_W-1:0];
          quo_r <= {quo_r[DIV_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

/* sv/dss_sqrt.sv */
module dss_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dss_pkg::DIV_W-1:0]   radicand,
  output logic                        done_r,
  output logic [dss_pkg::Q_W-1:0]     root
);
  import dss_pkg::*;

  logic [DIV_W-1:0] x_r;
  logic [DIV_W-1:0] r_r;
  logic [DIV_W-1:0] bit_r;
  logic             busy_r;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;

  // digit-by-digit square root, two radicand bits a cycle
  assign trial = {1'b0, r_r} + {1'b0, bit_r};
  assign diff  = {1'b0, x_r} - trial;
  assign root  = r_r[Q_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        x_r    <= radicand;
        r_r    <= '0;
        bit_r  <= DIV_W'(1) << (DIV_W - 2);
      end else if (busy_r) begin
        if (!diff[DIV_W]) begin
          x_r <= diff[DIV_W-1:0];
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[1:0] != 2'b00) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

/* sv/damped_spring_settle_step_top.sv */
// Channel | Direction | Handshake       | Payload
// in      | input     | in_valid/stall  | in_cmd, in_time_now
// out     | output    | out_valid/stall | out_position, out_stopped
// cfg     | input     | cfg_we          | cfg_index, cfg_wdata
//
// Accepting edge to result: a start goes straight to the hand-off; a sample
// with no time step goes to the energy test; any other sample runs set-up (three
// divisions and a square root; two divisions when omega is zero), two mass
// divisions per substep, the energy test on the shared multiplier, the hand-off.
// Reset is synchronous and active low; it clears state and registers.
// in_stall is high while a beat is in work; out_stall also stalls the hand-off.
module damped_spring_settle_step_top #(
  parameter int unsigned MAX_SUBSTEPS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_cmd,
  input  logic [30:0]                         in_time_now,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dss_pkg::Q_W-1:0]      out_position,
  output logic                                out_stopped,
  input  logic                                cfg_we,
  input  logic [dss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dss_pkg::Q_W-1:0]             cfg_wdata
);
  import dss_pkg::*;

  localparam int unsigned NW    = $clog2(MAX_SUBSTEPS + 1);
  localparam int unsigned ACC_W = 98;

  typedef enum logic [5:0] {
    ST_IDLE, ST_DT, ST_RDIV_GO, ST_RDIV_W, ST_SQ_GO, ST_SQ_W, ST_OD_CHK,
    ST_OD_MUL, ST_OD_GO, ST_OD_W, ST_HD_GO, ST_HD_W,
    ST_S_X, ST_S_M1, ST_S_M2, ST_S_N1, ST_S_D1, ST_S_D1W, ST_S_M3, ST_S_V1,
    ST_S_M4, ST_S_X1, ST_S_M5, ST_S_M6, ST_S_N2, ST_S_D2, ST_S_D2W, ST_S_M7,
    ST_S_DV, ST_S_M8, ST_S_P,
    ST_T_X, ST_T_M1, ST_T_M2, ST_T_M3, ST_T_M4, ST_T_M5, ST_T_M6, ST_T_M7,
    ST_T_M8, ST_T_M9, ST_T_DEC, ST_OUT
  } state_t;

  // configuration registers
  logic signed [Q_W-1:0] cfg_spos_r, cfg_tgt_r, cfg_svel_r;
  logic [30:0]           cfg_mass_r, cfg_stiff_r, cfg_damp_r, cfg_th_r;
  logic [1:0]            cfg_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_spos_r  <= '0;
      cfg_tgt_r   <= 32'sd65536;
      cfg_svel_r  <= '0;
      cfg_mass_r  <= 31'd65536;
      cfg_stiff_r <= 31'd65536;
      cfg_damp_r  <= 31'd6554;
      cfg_th_r    <= 31'd66;
      cfg_mode_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_POS: cfg_spos_r  <= cfg_wdata;
        CFG_TARGET:    cfg_tgt_r   <= cfg_wdata;
        CFG_START_VEL: cfg_svel_r  <= cfg_wdata;
        CFG_MASS:      cfg_mass_r  <= cfg_wdata[30:0];
        CFG_STIFF:     cfg_stiff_r <= cfg_wdata[30:0];
        CFG_DAMP:      cfg_damp_r  <= cfg_wdata[30:0];
        CFG_THRESH:    cfg_th_r    <= cfg_wdata[30:0];
        CFG_BOUNCE:    cfg_mode_r  <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  state_t                  state_r;
  logic signed [Q_W-1:0]   p_r, v_r, x_r, t1_r, num_r, a_r, v1_r, x1_r, v2_r;
  logic [Q_W-1:0]          prev_r;
  logic [30:0]             now_r;
  logic signed [Q_W-1:0]   dt_r;
  logic [46:0]             ratio_r;
  logic [Q_W-1:0]          omega_r;
  logic [Q_W-1:0]          h_r;
  logic [NW-1:0]           n_r, i_r;
  logic signed [MOP_W-1:0] xs_r;
  logic [63:0]             xx_r, vv_r, tt_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [Q_W-1:0]   res_pos_r;
  logic                    res_stop_r;
  logic                    out_valid_r;
  logic signed [Q_W-1:0]   out_pos_r;
  logic                    out_stop_r;

  // shared units
  logic signed [MOP_W-1:0] mul_a, mul_b;
  logic signed [MPR_W-1:0] mul_p;
  logic                    div_go, div_done;
  logic [DIV_W-1:0]        div_dvd, div_dvs, div_q;
  logic                    sq_go, sq_done;
  logic [Q_W-1:0]          sq_root;

  dss_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod_r(mul_p));

  dss_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go), .dividend(div_dvd),
    .divisor(div_dvs), .done_r(div_done), .quo_r(div_q)
  );

  dss_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_go), .radicand({1'b0, ratio_r, 16'd0}),
    .done_r(sq_done), .root(sq_root)
  );

  // operand selection for the shared multiplier and divider
  logic [30:0]    mass_nz;
  logic [32:0]    num_mag;
  assign mass_nz = (cfg_mass_r == '0) ? 31'd1 : cfg_mass_r;
  assign num_mag = num_r[Q_W-1] ? (33'd0 - {num_r[Q_W-1], num_r}) : {1'b0, num_r};

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_go  = 1'b0;
    div_dvd = '0;
    div_dvs = '0;
    sq_go   = (state_r == ST_SQ_GO);
    case (state_r)
      ST_OD_MUL: begin
        mul_a = {1'b0, omega_r};
        mul_b = {1'b0, dt_r};
      end
      ST_S_M1: begin
        mul_a = {2'b0, cfg_stiff_r};
        mul_b = {x_r[Q_W-1], x_r};
      end
      ST_S_M2: begin
        mul_a = {2'b0, cfg_damp_r};
        mul_b = {v_r[Q_W-1], v_r};
      end
      ST_S_M3: begin
        mul_a = {a_r[Q_W-1], a_r};
        mul_b = {1'b0, h_r};
      end
      ST_S_M4: begin
        mul_a = {1'b0, h_r};
        mul_b = {v1_r[Q_W-1], v1_r};
      end
      ST_S_M5: begin
        mul_a = {x1_r[Q_W-1], x1_r};
        mul_b = {2'b0, cfg_stiff_r};
      end
      ST_S_M6: begin
        mul_a = {v1_r[Q_W-1], v1_r};
        mul_b = {2'b0, cfg_damp_r};
      end
      ST_S_M7: begin
        mul_a = {a_r[Q_W-1], a_r};
        mul_b = {1'b0, h_r};
      end
      ST_S_M8: begin
        mul_a = {v2_r[Q_W-1], v2_r};
        mul_b = {1'b0, h_r};
      end
      ST_T_M1: begin
        mul_a = xs_r;
        mul_b = xs_r;
      end
      ST_T_M2: begin
        mul_a = {v_r[Q_W-1], v_r};
        mul_b = {v_r[Q_W-1], v_r};
      end
      ST_T_M3: begin
        mul_a = {2'b0, cfg_th_r};
        mul_b = {2'b0, cfg_th_r};
      end
      ST_T_M4: begin
        mul_a = {2'b0, cfg_mass_r};
        mul_b = {1'b0, vv_r[31:0]};
      end
      ST_T_M5: begin
        mul_a = {2'b0, cfg_mass_r};
        mul_b = {1'b0, vv_r[63:32]};
      end
      ST_T_M6: begin
        mul_a = {2'b0, cfg_stiff_r};
        mul_b = {1'b0, xx_r[31:0]};
      end
      ST_T_M7: begin
        mul_a = {2'b0, cfg_stiff_r};
        mul_b = {1'b0, xx_r[63:32]};
      end
      ST_T_M8: begin
        mul_a = {2'b0, cfg_stiff_r};
        mul_b = {1'b0, tt_r[31:0]};
      end
      ST_T_M9: begin
        mul_a = {2'b0, cfg_stiff_r};
        mul_b = {1'b0, tt_r[63:32]};
      end
      ST_RDIV_GO: begin
        div_go  = 1'b1;
        div_dvd = {17'd0, cfg_stiff_r, 16'd0};
        div_dvs = {33'd0, mass_nz};
      end
      ST_OD_GO: begin
        div_go  = 1'b1;
        div_dvd = DIV_W'(9) << 30;
        div_dvs = mul_p[DIV_W-1:0];
      end
      ST_HD_GO: begin
        div_go  = 1'b1;
        div_dvd = {32'd0, dt_r};
        div_dvs = DIV_W'(n_r);
      end
      ST_S_D1, ST_S_D2: begin
        div_go  = 1'b1;
        div_dvd = {15'd0, num_mag, 16'd0};
        div_dvs = {33'd0, mass_nz};
      end
      default: ;
    endcase
  end

  // scaled products, quotient with sign, and the end-of-substep update
  logic signed [Q_W-1:0]   qm16, qm17, qdv, p_sum, p_b1, v_b1, p_nxt, v_nxt;
  logic signed [MPR_W-1:0] qv;
  logic signed [ACC_W-1:0] prod_ext, acc_fin;

  assign qm16     = sat32(mul_p >>> 16);
  assign qm17     = sat32(mul_p >>> 17);
  assign qv       = {17'd0, div_q[48:0]};
  assign qdv      = num_r[Q_W-1] ? sat32(-qv) : sat32(qv);
  assign prod_ext = ACC_W'(mul_p);
  assign acc_fin  = acc_r - (prod_ext <<< 32);

  always_comb begin
    p_sum = sat32(MPR_W'(p_r) + MPR_W'(qm16));
    p_b1  = p_sum;
    v_b1  = v_r;
    if (cfg_mode_r[0] && p_sum < 0) begin
      p_b1 = sat32(-MPR_W'(p_sum));
      v_b1 = sat32(-MPR_W'(v_r));
    end
    p_nxt = p_b1;
    v_nxt = v_b1;
    if (cfg_mode_r[1] && p_b1 > 32'sd65536) begin
      p_nxt = sat32(MPR_W'(32'sd131072) - MPR_W'(p_b1));
      v_nxt = sat32(-MPR_W'(v_b1));
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      p_r         <= '0;
      v_r         <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // ST_OUT reloads the output register itself
      if (out_valid_r && !out_stall && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_cmd == CMD_START) begin
              p_r        <= cfg_spos_r;
              v_r        <= cfg_svel_r;
              prev_r     <= '0;
              res_pos_r  <= cfg_spos_r;
              res_stop_r <= 1'b0;
              state_r    <= ST_OUT;
            end else begin
              dt_r    <= $signed({1'b0, in_time_now}) - $signed(prev_r);
              now_r   <= in_time_now;
              state_r <= ST_DT;
            end
          end
        end
        ST_DT: begin
          prev_r  <= {1'b0, now_r};
          state_r <= (dt_r > 0) ? ST_RDIV_GO : ST_T_X;
        end
        ST_RDIV_GO: state_r <= ST_RDIV_W;
        ST_RDIV_W: begin
          if (div_done) begin
            ratio_r <= div_q[46:0];
            state_r <= ST_SQ_GO;
          end
        end
        ST_SQ_GO: state_r <= ST_SQ_W;
        ST_SQ_W: begin
          if (sq_done) begin
            omega_r <= sq_root;
            state_r <= ST_OD_CHK;
          end
        end
        ST_OD_CHK: begin
          if (omega_r == '0) begin
            n_r     <= NW'(MAX_SUBSTEPS);
            state_r <= ST_HD_GO;
          end else begin
            state_r <= ST_OD_MUL;
          end
        end
        ST_OD_MUL: state_r <= ST_OD_GO;
        ST_OD_GO:  state_r <= ST_OD_W;
        ST_OD_W: begin
          if (div_done) begin
            if (div_q < DIV_W'(MAX_SUBSTEPS - 1)) begin
              n_r <= div_q[NW-1:0] + NW'(1);
            end else begin
              n_r <= NW'(MAX_SUBSTEPS);
            end
            state_r <= ST_HD_GO;
          end
        end
        ST_HD_GO: state_r <= ST_HD_W;
        ST_HD_W: begin
          if (div_done) begin
            h_r     <= div_q[Q_W-1:0];
            i_r     <= '0;
            state_r <= ST_S_X;
          end
        end
        // one midpoint substep
        ST_S_X: begin
          x_r     <= sat32(MPR_W'(p_r) - MPR_W'(cfg_tgt_r));
          state_r <= ST_S_M1;
        end
        ST_S_M1: state_r <= ST_S_M2;
        ST_S_M2: begin
          t1_r    <= qm16;
          state_r <= ST_S_N1;
        end
        ST_S_N1: begin
          num_r   <= sat32(MPR_W'(0) - MPR_W'(t1_r) - MPR_W'(qm16));
          state_r <= ST_S_D1;
        end
        ST_S_D1: state_r <= ST_S_D1W;
        ST_S_D1W: begin
          if (div_done) begin
            a_r     <= qdv;
            state_r <= ST_S_M3;
          end
        end
        ST_S_M3: state_r <= ST_S_V1;
        ST_S_V1: begin
          v1_r    <= sat32(MPR_W'(v_r) + MPR_W'(qm17));
          state_r <= ST_S_M4;
        end
        ST_S_M4: state_r <= ST_S_X1;
        ST_S_X1: begin
          x1_r    <= sat32(MPR_W'(p_r) + MPR_W'(qm17) - MPR_W'(cfg_tgt_r));
          state_r <= ST_S_M5;
        end
        ST_S_M5: state_r <= ST_S_M6;
        ST_S_M6: begin
          t1_r    <= qm16;
          state_r <= ST_S_N2;
        end
        ST_S_N2: begin
          num_r   <= sat32(MPR_W'(0) - MPR_W'(t1_r) - MPR_W'(qm16));
          state_r <= ST_S_D2;
        end
        ST_S_D2: state_r <= ST_S_D2W;
        ST_S_D2W: begin
          if (div_done) begin
            a_r     <= qdv;
            state_r <= ST_S_M7;
          end
        end
        ST_S_M7: state_r <= ST_S_DV;
        ST_S_DV: begin
          v2_r    <= sat32(MPR_W'(v_r) + MPR_W'(qm16 >>> 1));
          v_r     <= sat32(MPR_W'(v_r) + MPR_W'(qm16));
          state_r <= ST_S_M8;
        end
        ST_S_M8: state_r <= ST_S_P;
        ST_S_P: begin
          p_r <= p_nxt;
          v_r <= v_nxt;
          i_r <= i_r + NW'(1);
          state_r <= (i_r + NW'(1) == n_r) ? ST_T_X : ST_S_X;
        end
        // energy test: m*v^2 + k*x^2 - k*th^2 <= 0
        ST_T_X: begin
          xs_r    <= {p_r[Q_W-1], p_r} - {cfg_tgt_r[Q_W-1], cfg_tgt_r};
          state_r <= ST_T_M1;
        end
        ST_T_M1: state_r <= ST_T_M2;
        ST_T_M2: begin
          xx_r    <= mul_p[63:0];
          state_r <= ST_T_M3;
        end
        ST_T_M3: begin
          vv_r    <= mul_p[63:0];
          state_r <= ST_T_M4;
        end
        ST_T_M4: begin
          tt_r    <= mul_p[63:0];
          state_r <= ST_T_M5;
        end
        ST_T_M5: begin
          acc_r   <= prod_ext;
          state_r <= ST_T_M6;
        end
        ST_T_M6: begin
          acc_r   <= acc_r + (prod_ext <<< 32);
          state_r <= ST_T_M7;
        end
        ST_T_M7: begin
          acc_r   <= acc_r + prod_ext;
          state_r <= ST_T_M8;
        end
        ST_T_M8: begin
          acc_r   <= acc_r + (prod_ext <<< 32);
          state_r <= ST_T_M9;
        end
        ST_T_M9: begin
          acc_r   <= acc_r - prod_ext;
          state_r <= ST_T_DEC;
        end
        ST_T_DEC: begin
          if (acc_fin <= 0) begin
            p_r        <= cfg_tgt_r;
            res_pos_r  <= cfg_tgt_r;
            res_stop_r <= 1'b1;
          end else begin
            res_pos_r  <= p_r;
            res_stop_r <= 1'b0;
          end
          state_r <= ST_OUT;
        end
        // hand the result to the output register
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_pos_r   <= res_pos_r;
            out_stop_r  <= res_stop_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_position = out_pos_r;
  assign out_stopped  = out_stop_r;

endmodule

/* tb/tb_damped_spring_settle_step_top.sv */
module tb_damped_spring_settle_step_top;
  import dss_pkg::*;

  localparam int unsigned SUBSTEP_CAP = 64;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_cmd;
  logic [30:0]           in_time_now;
  logic                  out_valid;
  logic                  out_stall;
  logic signed [Q_W-1:0] out_position;
  logic                  out_stopped;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [Q_W-1:0]        cfg_wdata;

  damped_spring_settle_step_top #(.MAX_SUBSTEPS(SUBSTEP_CAP)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_time_now(in_time_now),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_position(out_position), .out_stopped(out_stopped),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  typedef struct packed {
    logic signed [31:0] position;
    logic               stopped;
  } settle_t;

  typedef struct {
    logic        cmd;
    logic [30:0] t;
    bit          known;
    settle_t     res;
  } dir_row_t;

  settle_t settle_q[$];
  int      errors;
  bit      calm;

  // mirrored register file and spring state
  int          m_start_pos, m_target, m_start_vel;
  logic [30:0] m_mass, m_stiff, m_damp, m_thresh;
  logic [1:0]  m_bounce;
  int          s_pos, s_vel;
  longint      s_prev;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // ---------------- fixed point helpers ----------------
  function automatic int clamp_q(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int fx_mul(int a, int b, int s);
    return clamp_q((longint'(a) * longint'(b)) >>> s);
  endfunction

  function automatic int fx_div_mass(int a);
    longint d;
    d = (m_mass == 0) ? 64'sd1 : longint'({33'b0, m_mass});
    return clamp_q((longint'(a) * 64'sd65536) / d);
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // one midpoint substep with optional mirror bounces
  task automatic spring_substep(int h);
    int k, c, p, v, x, a, v1, x1, a2, dv, v2;
    k  = int'({1'b0, m_stiff});
    c  = int'({1'b0, m_damp});
    p  = s_pos;
    v  = s_vel;
    x  = clamp_q(longint'(p) - m_target);
    a  = fx_div_mass(clamp_q(-longint'(fx_mul(k, x, 16)) - fx_mul(c, v, 16)));
    v1 = clamp_q(longint'(v) + fx_mul(a, h, 17));
    x1 = clamp_q(longint'(p) + fx_mul(h, v1, 17) - m_target);
    a2 = fx_div_mass(clamp_q(-longint'(fx_mul(x1, k, 16)) - fx_mul(v1, c, 16)));
    dv = fx_mul(a2, h, 16);
    v2 = clamp_q(longint'(v) + (longint'(dv) >>> 1));
    v  = clamp_q(longint'(v) + dv);
    p  = clamp_q(longint'(p) + fx_mul(v2, h, 16));
    if (m_bounce[0] && p < 0) begin
      p = clamp_q(-longint'(p));
      v = clamp_q(-longint'(v));
    end
    if (m_bounce[1] && p > 65536) begin
      p = clamp_q(64'sd131072 - p);
      v = clamp_q(-longint'(v));
    end
    s_pos = p;
    s_vel = v;
  endtask

  // energy test: m*v^2 + k*x^2 <= k*th^2, exact with 64-bit square wrap
  function automatic bit at_rest();
    longint       x, v;
    logic [63:0]  ax, av, sx, sv, st;
    logic [127:0] lhs, rhs;
    x   = longint'(s_pos) - m_target;
    v   = s_vel;
    ax  = (x < 0) ? -x : x;
    av  = (v < 0) ? -v : v;
    sx  = ax * ax;
    sv  = av * av;
    st  = {33'b0, m_thresh} * {33'b0, m_thresh};
    lhs = {97'b0, m_mass} * {64'b0, sv} + {97'b0, m_stiff} * {64'b0, sx};
    rhs = {97'b0, m_stiff} * {64'b0, st};
    return lhs <= rhs;
  endfunction

  task automatic settle_step(logic cmd, logic [30:0] now, output settle_t r);
    longint              dt, h;
    longint unsigned     ms, ratio, omega, q;
    int                  n;
    r.stopped = 1'b0;
    if (cmd == CMD_START) begin
      s_pos  = m_start_pos;
      s_vel  = m_start_vel;
      s_prev = 0;
    end else begin
      dt = longint'({33'b0, now}) - s_prev;
      if (dt > 0) begin
        ms    = (m_mass == 0) ? 64'd1 : {33'b0, m_mass};
        ratio = ({33'b0, m_stiff} << 16) / ms;
        omega = root64(ratio << 16);
        n     = SUBSTEP_CAP;
        if (omega != 0) begin
          q = (64'd9 << 30) / (omega * longint'(dt));
          if (q < SUBSTEP_CAP - 1) n = int'(q) + 1;
        end
        h = dt / n;
        for (int i = 0; i < n; i++) spring_substep(int'(h));
      end
      s_prev = {33'b0, now};
      if (at_rest()) begin
        s_pos     = m_target;
        r.stopped = 1'b1;
      end
    end
    r.position = s_pos;
  endtask

  // ---------------- drivers ----------------
  task automatic send_beat(logic cmd, logic [30:0] now, bit known, settle_t given);
    settle_t r;
    if (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 24) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_time_now <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    settle_step(cmd, now, r);
    settle_q.push_back(known ? given : r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (settle_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write enable stays high across a burst; load_all drops it at the end
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    case (idx)
      CFG_START_POS: m_start_pos = d;
      CFG_TARGET:    m_target    = d;
      CFG_START_VEL: m_start_vel = d;
      CFG_MASS:      m_mass      = d[30:0];
      CFG_STIFF:     m_stiff     = d[30:0];
      CFG_DAMP:      m_damp      = d[30:0];
      CFG_THRESH:    m_thresh    = d[30:0];
      default:       m_bounce    = d[1:0];
    endcase
  endtask

  task automatic load_all(logic [31:0] sp, logic [31:0] tg, logic [31:0] sv, logic [31:0] ma,
                          logic [31:0] st, logic [31:0] da, logic [31:0] th, logic [31:0] bm);
    wait_drained();
    write_reg(CFG_START_POS, sp);
    write_reg(CFG_TARGET, tg);
    write_reg(CFG_START_VEL, sv);
    write_reg(CFG_MASS, ma);
    write_reg(CFG_STIFF, st);
    write_reg(CFG_DAMP, da);
    write_reg(CFG_THRESH, th);
    write_reg(CFG_BOUNCE, bm);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rnd_signed(int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  // result receiver stalls
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 24);
    end
  end

  // result checker
  always @(posedge clk) begin
    settle_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (settle_q.size() == 0) begin
        $display("%0t: unexpected beat position %h stopped %b", $time, out_position,
                 out_stopped);
        errors++;
      end else begin
        want = settle_q.pop_front();
        if (out_position !== want.position) begin
          $display("%0t: position expected %h actual %h", $time, want.position, out_position);
          errors++;
        end
        if (out_stopped !== want.stopped) begin
          $display("%0t: stopped expected %b actual %b", $time, want.stopped, out_stopped);
          errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    dir_row_t    rows[$];
    dir_row_t    row;
    logic [30:0] t;
    longint      nt;
    int          pick, count;
    settle_t     none;
    none        = '0;
    errors      = 0;
    calm        = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_cmd      = CMD_START;
    in_time_now = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_START_POS;
    cfg_wdata   = '0;
    m_start_pos = 0; m_target = 65536; m_start_vel = 0;
    m_mass = 65536; m_stiff = 65536; m_damp = 6554; m_thresh = 66; m_bounce = 0;
    s_pos = 0; s_vel = 0; s_prev = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows with reset registers
    rows = '{
      '{CMD_START,  31'd0,          1'b1, '{32'sd0, 1'b0}},
      '{CMD_SAMPLE, 31'd0,          1'b1, '{32'sd0, 1'b0}},
      '{CMD_SAMPLE, 31'd65536,      1'b0, '{32'sd0, 1'b0}},
      '{CMD_SAMPLE, 31'd65536,      1'b0, '{32'sd0, 1'b0}},
      '{CMD_SAMPLE, 31'd32768,      1'b0, '{32'sd0, 1'b0}},
      '{CMD_SAMPLE, 31'h7fffffff,   1'b0, '{32'sd0, 1'b0}},
      '{CMD_START,  31'h7fffffff,   1'b1, '{32'sd0, 1'b0}},
      '{CMD_SAMPLE, 31'd1,          1'b0, '{32'sd0, 1'b0}},
      '{CMD_SAMPLE, 31'd2,          1'b0, '{32'sd0, 1'b0}},
      '{CMD_SAMPLE, 31'd131072,     1'b0, '{32'sd0, 1'b0}},
      '{CMD_SAMPLE, 31'd655360,     1'b0, '{32'sd0, 1'b0}},
      '{CMD_SAMPLE, 31'd6553600,    1'b0, '{32'sd0, 1'b0}},
      '{CMD_SAMPLE, 31'd6553600,    1'b0, '{32'sd0, 1'b0}},
      '{CMD_SAMPLE, 31'h55555555,   1'b0, '{32'sd0, 1'b0}},
      '{CMD_START,  31'h2aaaaaaa,   1'b1, '{32'sd0, 1'b0}}
    };
    foreach (rows[i]) begin
      row = rows[i];
      send_beat(row.cmd, row.t, row.known, row.res);
    end

    // overflow extremes, then zero mass and zero stiffness
    load_all(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
             32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'd3);
    send_beat(CMD_START, 31'd0, 1'b1, '{32'sh7fffffff, 1'b0});
    send_beat(CMD_SAMPLE, 31'd65536, 1'b0, none);
    send_beat(CMD_SAMPLE, 31'h7fffffff, 1'b0, none);
    load_all(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'd0,
             32'd0, 32'd0, 32'd0, 32'd0);
    send_beat(CMD_START, 31'd0, 1'b1, '{32'sh80000000, 1'b0});
    send_beat(CMD_SAMPLE, 31'd100, 1'b0, none);
    send_beat(CMD_SAMPLE, 31'd100, 1'b0, none);
    load_all(32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd66, 32'd1);
    send_beat(CMD_START, 31'd0, 1'b0, none);
    send_beat(CMD_SAMPLE, 31'd65536, 1'b0, none);

    // random phases, one register setting each
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_all(32'd0, 32'd65536, 32'd0, 32'd65536, 32'd65536, 32'd6554, 32'd66, 32'd0);
        1: load_all(rnd_signed(131072), 32'd32768, rnd_signed(262144), 32'd65536,
                    32'd262144, 32'd16384, 32'd655, 32'd3);
        2: load_all($urandom(), $urandom(), $urandom(), 32'd1, 32'h7fffffff,
                    $urandom(), $urandom(), $urandom_range(3));
        default: load_all(rnd_signed(200000), rnd_signed(200000), rnd_signed(400000),
                          $urandom_range(16384, 262144), $urandom_range(16384, 1048576),
                          $urandom_range(0, 262144), $urandom_range(0, 4000),
                          $urandom_range(3));
      endcase
      calm  = (ph == 4);
      t     = 0;
      count = 70;
      send_beat(CMD_START, 31'($urandom()), 1'b0, none);
      for (int i = 0; i < count; i++) begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          t = 0;
          send_beat(CMD_START, 31'($urandom()), 1'b0, none);
        end else if (pick < 10) begin
          // time stands still or runs backwards
          t = (pick < 8) ? t : 31'($urandom_range(0, t));
          send_beat(CMD_SAMPLE, t, 1'b0, none);
        end else if (pick < 13) begin
          nt = longint'(t) + $urandom_range(1, 64);
          t  = (nt > 64'h7fffffff) ? 31'h7fffffff : 31'(nt);
          send_beat(CMD_SAMPLE, t, 1'b0, none);
        end else if (pick < 15) begin
          t = 31'($urandom());
          send_beat(CMD_SAMPLE, t, 1'b0, none);
        end else begin
          nt = longint'(t) + $urandom_range(16384, 400000);
          t  = (nt > 64'h7fffffff) ? 31'h7fffffff : 31'(nt);
          send_beat(CMD_SAMPLE, t, 1'b0, none);
        end
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #400000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
